// ===== rtl/core/pdid_pkg.sv =====
// Package for the predictive delta image decoder.
// Holds shared types, codes and default sizes; no dependencies.
package pdid_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int MIN_WIDTH      = 4;
  localparam int MIN_HEIGHT     = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int COL_W          = 12;   // column index, covers widths up to 4096
  localparam int CFG_REG_W      = 11;
  localparam int CFG_AW         = 3;

  localparam logic [CFG_REG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_REG_W-1:0] HEIGHT_RESET = 11'd768;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_CODES = 2'd0,
    PH_RAW   = 2'd1,
    PH_DELTA = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CD_BYTE  = 2'd0,
    CD_HALF  = 2'd1,
    CD_WORD  = 2'd2,
    CD_UNDEF = 2'd3
  } code_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_CODE = 2'd2
  } status_t;

  // One pixel request handed from the parser to the reconstruction side
  typedef struct packed {
    logic [31:0]      diff;
    logic             raw;
    logic             last;
    status_t          status;
    logic [COL_W-1:0] col;
  } job_t;

endpackage

// ===== rtl/core/pdid_if.sv =====
// Stream interfaces for the decoder: byte input and pixel output.
// Valid/ready handshake; no dependencies.
interface pdid_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pdid_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic        last_pixel;
  logic [1:0]  status;

  modport source (output valid, output pixel_value, output last_pixel, output status,
                  input ready);
  modport sink   (input valid, input pixel_value, input last_pixel, input status,
                  output ready);
endinterface

// ===== rtl/core/pdid_front.sv =====
// Front end: takes file bytes, stores code bytes, assembles pixel differences.
// Depends on pdid_pkg and pdid_byte_if; feeds pixel requests to the queue.
module pdid_front
  import pdid_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CODE_DEPTH = ((MAX_HEIGHT - 1) * MAX_WIDTH) / 4 + 1,
  localparam int CAW  = $clog2(CODE_DEPTH),
  localparam int BCW  = $clog2(CODE_DEPTH + 1),
  localparam int TOTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
  localparam int WW   = $clog2(MAX_WIDTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  pdid_byte_if.sink       in_stream,
  input  logic [WW-1:0]   geom_w,
  input  logic [BCW-1:0]  geom_ncodes,
  input  logic [TOTW-1:0] geom_total,
  input  logic            q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [7:0]       code_mem [CODE_DEPTH];
  logic [7:0]       cur_byte_r;

  phase_t           phase_r, phase_nxt;
  logic [BCW-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [TOTW-1:0]  pix_cnt_r, pix_cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [31:0]      asm_r, asm_nxt;
  logic [1:0]       gath_r, gath_nxt;
  logic [BCW-1:0]   cidx_r, cidx_nxt;
  logic [1:0]       slot_r, slot_nxt;

  logic             accept;
  logic             mem_we;
  phase_t           ph;
  logic [31:0]      asm_cur;
  logic [1:0]       gath_cur;
  code_t            code;
  logic [2:0]       need;
  logic [2:0]       g1;
  logic [31:0]      word;
  logic [31:0]      diff;
  logic [TOTW-1:0]  pix1;
  logic [COL_W:0]   col1;

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && in_stream.ready;

  always_comb begin
    ph       = phase_r;
    asm_cur  = asm_r;
    gath_cur = gath_r;
    if (phase_r == PH_CODES && byte_cnt_r >= geom_ncodes) begin
      ph       = PH_RAW;
      asm_cur  = '0;
      gath_cur = '0;
    end

    if (ph == PH_DELTA) begin
      if (cidx_r >= geom_ncodes) code = CD_BYTE;
      else                       code = code_t'(cur_byte_r[{slot_r, 1'b0} +: 2]);
    end else begin
      code = CD_WORD;
    end

    unique case (code)
      CD_BYTE: need = 3'd1;
      CD_HALF: need = 3'd2;
      default: need = 3'd4;
    endcase

    g1   = {1'b0, gath_cur} + 3'd1;
    word = asm_cur | (32'(in_stream.data_byte) << {gath_cur, 3'b000});
    unique case (code)
      CD_BYTE: diff = {{24{word[7]}}, word[7:0]};
      CD_HALF: diff = {{16{word[15]}}, word[15:0]};
      default: diff = word;
    endcase
    pix1 = pix_cnt_r + TOTW'(1);
    col1 = {1'b0, col_r} + (COL_W+1)'(1);

    phase_nxt    = phase_r;
    byte_cnt_nxt = byte_cnt_r;
    pix_cnt_nxt  = pix_cnt_r;
    col_nxt      = col_r;
    asm_nxt      = asm_r;
    gath_nxt     = gath_r;
    cidx_nxt     = cidx_r;
    slot_nxt     = slot_r;
    mem_we       = 1'b0;
    q_push       = 1'b0;
    q_job        = '{diff: diff, raw: (ph == PH_RAW), last: 1'b0, status: ST_OK, col: col_r};

    if (accept && phase_r != PH_DONE) begin
      asm_nxt  = asm_cur;
      gath_nxt = gath_cur;
      phase_nxt = ph;
      if (ph != PH_CODES && pix_cnt_r >= geom_total) begin
        phase_nxt = PH_DONE;
      end else if (ph == PH_DELTA && code == CD_UNDEF) begin
        q_push       = 1'b1;
        q_job.diff   = '0;
        q_job.status = ST_BAD_CODE;
        phase_nxt    = PH_DONE;
      end else if (in_stream.end_of_stream) begin
        q_push       = 1'b1;
        q_job.diff   = '0;
        q_job.status = ST_TRUNC;
        phase_nxt    = PH_DONE;
      end else if (ph == PH_CODES) begin
        mem_we       = (byte_cnt_r < BCW'(CODE_DEPTH));
        byte_cnt_nxt = byte_cnt_r + BCW'(1);
        if (byte_cnt_nxt >= geom_ncodes) phase_nxt = PH_RAW;
      end else if (g1 < need) begin
        asm_nxt  = word;
        gath_nxt = g1[1:0];
      end else begin
        q_push      = 1'b1;
        asm_nxt     = '0;
        gath_nxt    = '0;
        pix_cnt_nxt = pix1;
        col_nxt     = (col1 == (COL_W+1)'(geom_w)) ? '0 : col1[COL_W-1:0];
        if (ph == PH_DELTA) begin
          slot_nxt = slot_r + 2'd1;
          if (slot_r == 2'd3) cidx_nxt = cidx_r + BCW'(1);
        end
        if (ph == PH_RAW && pix_cnt_r >= TOTW'(geom_w)) phase_nxt = PH_DELTA;
        if (pix1 >= geom_total) begin
          phase_nxt  = PH_DONE;
          q_job.last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CODES;
      byte_cnt_r <= '0;
      pix_cnt_r  <= '0;
      col_r      <= '0;
      asm_r      <= '0;
      gath_r     <= '0;
      cidx_r     <= '0;
      slot_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
      col_r      <= col_nxt;
      asm_r      <= asm_nxt;
      gath_r     <= gath_nxt;
      cidx_r     <= cidx_nxt;
      slot_r     <= slot_nxt;
    end
  end

  // code byte of the current pixel, read with next-state index so it is always aligned
  always_ff @(posedge clk) begin
    if (mem_we) code_mem[byte_cnt_r[CAW-1:0]] <= in_stream.data_byte;
    cur_byte_r <= code_mem[cidx_nxt[CAW-1:0]];
  end

endmodule

// ===== rtl/core/pdid_queue.sv =====
// Short request queue between front end and reconstruction.
// Depends on pdid_pkg for job_t.
module pdid_queue
  import pdid_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_job;
  end

endmodule

// ===== rtl/core/pdid_back.sv =====
// Back end: row buffer read, left+up-upleft+diff, output register.
// Depends on pdid_pkg and pdid_pix_if.
module pdid_back
  import pdid_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int RAW_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_head,
  output logic        q_pop,
  pdid_pix_if.source  out_stream
);

  logic [31:0] row_mem [MAX_WIDTH];

  logic        a_valid_r;
  job_t        a_job_r;
  logic [31:0] up_r;
  logic [31:0] left_r;
  logic [31:0] ul_r;
  logic        out_valid_r;
  logic [31:0] out_pix_r;
  logic        out_last_r;
  status_t     out_status_r;

  logic        adv_out;
  logic        pix_ok;
  logic [31:0] pix;

  assign adv_out = a_valid_r && (!out_valid_r || out_stream.ready);
  assign q_pop   = q_valid && (!a_valid_r || adv_out);
  assign pix_ok  = (a_job_r.status == ST_OK);
  assign pix     = a_job_r.raw ? a_job_r.diff : left_r + up_r - ul_r + a_job_r.diff;

  assign out_stream.valid       = out_valid_r;
  assign out_stream.pixel_value = out_pix_r;
  assign out_stream.last_pixel  = out_last_r;
  assign out_stream.status      = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      ul_r        <= '0;
    end else begin
      if (q_pop)        a_valid_r <= 1'b1;
      else if (adv_out) a_valid_r <= 1'b0;
      if (adv_out) begin
        out_valid_r <= 1'b1;
        if (pix_ok) begin
          left_r <= pix;
          ul_r   <= up_r;
        end
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_job_r <= q_head;
      up_r    <= row_mem[q_head.col[RAW_W-1:0]];
    end
    if (adv_out) begin
      out_pix_r    <= pix_ok ? pix : '0;
      out_last_r   <= a_job_r.last && pix_ok;
      out_status_r <= a_job_r.status;
      if (pix_ok) row_mem[a_job_r.col[RAW_W-1:0]] <= pix;
    end
  end

endmodule

// ===== rtl/core/predictive_delta_image_decoder.sv =====
// Channel    | Dir | Handshake              | Payload
// in_stream  | in  | valid/ready            | data_byte[7:0], end_of_stream
// out_stream | out | valid/ready            | pixel_value[31:0], last_pixel, status[1:0]
// cfg_*      | in  | APB, pready tied high  | image_width @0x0, image_height @0x4
//
// One byte request per cycle while the request queue has room; after its last byte a pixel
// passes through the request queue, the back end's stage register and the output register.
// Synchronous active-low reset; no clearing pass, stores are valid once written.
// Input stalls only when the four-entry request queue fills behind a stalled output.
//
// Top level of the predictive delta image decoder. Depends on pdid_pkg, pdid_if,
// pdid_front, pdid_queue and pdid_back.
module predictive_delta_image_decoder
  import pdid_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  pdid_byte_if.sink         in_stream,
  pdid_pix_if.source        out_stream,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int CODE_DEPTH = ((MAX_HEIGHT - 1) * MAX_WIDTH) / 4 + 1;
  localparam int BCW  = $clog2(CODE_DEPTH + 1);
  localparam int TOTW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);

  logic [CFG_REG_W-1:0] width_r, height_r;
  logic [WW-1:0]        w_clamp;
  logic [HW-1:0]        h_clamp;
  logic [BCW-1:0]       geom_ncodes;
  logic [TOTW-1:0]      geom_total;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  logic q_full, q_push, q_pop, q_valid;
  job_t q_job, q_head;

  // --- configuration port ---
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_WIDTH:  cfg_prdata = 32'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = 32'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_IMAGE_WIDTH)  width_r  <= cfg_pwdata[CFG_REG_W-1:0];
      if (cfg_idx == REG_IMAGE_HEIGHT) height_r <= cfg_pwdata[CFG_REG_W-1:0];
    end
  end

  // --- geometry: saturate registers, then precompute counts (one multiply each) ---
  always_comb begin
    if (32'(width_r) < 32'(MIN_WIDTH))       w_clamp = WW'(MIN_WIDTH);
    else if (32'(width_r) > 32'(MAX_WIDTH))  w_clamp = WW'(MAX_WIDTH);
    else                                     w_clamp = WW'(width_r);
    if (32'(height_r) < 32'(MIN_HEIGHT))     h_clamp = HW'(MIN_HEIGHT);
    else if (32'(height_r) > 32'(MAX_HEIGHT)) h_clamp = HW'(MAX_HEIGHT);
    else                                     h_clamp = HW'(height_r);
  end

  // counts follow the registers directly, so a write applies to the very next request
  always_comb begin
    geom_total  = TOTW'(32'(w_clamp) * 32'(h_clamp));
    geom_ncodes = BCW'((32'(h_clamp - HW'(1)) * 32'(w_clamp)) >> 2);
  end

  // --- front end: parse bytes, emit pixel requests ---
  pdid_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stream   (in_stream),
    .geom_w      (w_clamp),
    .geom_ncodes (geom_ncodes),
    .geom_total  (geom_total),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  // --- decoupling queue ---
  pdid_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // --- back end: prediction and output register ---
  pdid_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule

// ===== rtl/core/pdid_checker.sv =====
// Port-level checks for the decoder output stream, bound to the top level.
// Depends on pdid_pkg.
module pdid_checker
  import pdid_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel,
  input logic        out_last,
  input logic [1:0]  out_status
);

  logic stop_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) stop_seen_r <= 1'b0;
    else if (out_valid && out_ready && (out_last || out_status != ST_OK)) stop_seen_r <= 1'b1;
  end

  a_err_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_pixel == '0 && !out_last)
    else $error("error result carries pixel data");

  a_no_undef_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_TRUNC || out_status == ST_BAD_CODE)
    else $error("status code out of range");

  a_quiet_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
    stop_seen_r |-> !out_valid)
    else $error("result after last pixel or error");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind predictive_delta_image_decoder pdid_checker u_pdid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .out_pixel  (out_stream.pixel_value),
  .out_last   (out_stream.last_pixel),
  .out_status (out_stream.status)
);
